FILE: sv/vspvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vspvc_pkg
// Shared constants, types and the angle table for the velocity controller.
// ----------------------------------------------------------------------------
package vspvc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_ENTRIES    = 24;

  // cordic datapath width: the scaled speed reaches about 2^44 with cordic gain
  localparam int CW = 48;

  localparam logic [31:0] TURN_HALF = 32'h8000_0000;
  localparam logic [31:0] CORDIC_K  = 32'd652032874;

  // configuration register indexes
  localparam logic [2:0] REG_TARGET_WIDTH  = 3'd0;
  localparam logic [2:0] REG_TARGET_CENTER = 3'd1;
  localparam logic [2:0] REG_DIST_KP       = 3'd2;
  localparam logic [2:0] REG_DIST_KI       = 3'd3;
  localparam logic [2:0] REG_TURN_KP       = 3'd4;
  localparam logic [2:0] REG_TURN_KI       = 3'd5;
  localparam logic [2:0] REG_STEP_TIME     = 3'd6;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture the accepted item and start
    logic att_init;  // set up atan2 vectoring
    logic integ;     // update both integrators
    logic mul_a;     // first command products
    logic mul_b;     // second command products
    logic cmd;       // sum, clamp and round commands
    logic rot_init;  // set up the rotation
    logic iter;      // one cordic step
    logic head_wr;   // store heading
    logic fin;       // round velocity into output register
  } vspvc_cmd_t;

  typedef struct packed {
    logic is_att;
    logic iter_last;
  } vspvc_sts_t;

  function automatic logic [31:0] angle_at(input logic [4:0] i);
    logic [31:0] a;
    begin
      unique case (i)
        5'd0:  a = 32'h20000000; 5'd1:  a = 32'h12E4051E;
        5'd2:  a = 32'h09FB385B; 5'd3:  a = 32'h051111D4;
        5'd4:  a = 32'h028B0D43; 5'd5:  a = 32'h0145D7E1;
        5'd6:  a = 32'h00A2F61E; 5'd7:  a = 32'h00517C55;
        5'd8:  a = 32'h0028BE53; 5'd9:  a = 32'h00145F2F;
        5'd10: a = 32'h000A2F98; 5'd11: a = 32'h000517CC;
        5'd12: a = 32'h00028BE6; 5'd13: a = 32'h000145F3;
        5'd14: a = 32'h0000A2FA; 5'd15: a = 32'h0000517D;
        5'd16: a = 32'h000028BE; 5'd17: a = 32'h0000145F;
        5'd18: a = 32'h00000A30; 5'd19: a = 32'h00000518;
        5'd20: a = 32'h0000028C; 5'd21: a = 32'h00000146;
        5'd22: a = 32'h000000A3; 5'd23: a = 32'h00000051;
        default: a = 32'h0;
      endcase
      return a;
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/visual_servo_pi_velocity_controller_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// visual_servo_pi_velocity_controller_unit
// Dual PI velocity controller with heading rotation, valid/ready channels.
// ----------------------------------------------------------------------------
// One item at a time. An attitude item runs atan2 vectoring in a shared
// one-step-per-cycle cordic and gives no result; a box item runs
// integration, the distance and turn products, command rounding and the
// rotation in the same cordic, and gives one result. The result sits in an
// output register, so the next item is accepted while it waits.
// Configuration is written any time the block is idle; no clearing pass
// follows reset.
module visual_servo_pi_velocity_controller_unit #(
  parameter int CORDIC_STEPS = vspvc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_action,
  input  wire logic [11:0]        in_box_width,
  input  wire logic [11:0]        in_box_center,
  input  wire logic signed [15:0] in_quat_w,
  input  wire logic signed [15:0] in_quat_x,
  input  wire logic signed [15:0] in_quat_y,
  input  wire logic signed [15:0] in_quat_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_vel_north,
  output logic signed [15:0]      out_vel_east,
  output logic signed [14:0]      out_yaw_rate,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  vspvc_pkg::vspvc_cmd_t cmd;
  vspvc_pkg::vspvc_sts_t sts;

  logic [11:0] tw_r, tc_r;
  logic [15:0] dkp_r, dki_r, tkp_r, tki_r, st_r;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r <= 12'd50; tc_r <= 12'd127;
      dkp_r <= 16'd655; dki_r <= 16'd655; tkp_r <= 16'd655; tki_r <= 16'd655;
      st_r <= 16'd2163;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vspvc_pkg::REG_TARGET_WIDTH:  tw_r  <= cfg_data[11:0];
        vspvc_pkg::REG_TARGET_CENTER: tc_r  <= cfg_data[11:0];
        vspvc_pkg::REG_DIST_KP:       dkp_r <= cfg_data;
        vspvc_pkg::REG_DIST_KI:       dki_r <= cfg_data;
        vspvc_pkg::REG_TURN_KP:       tkp_r <= cfg_data;
        vspvc_pkg::REG_TURN_KI:       tki_r <= cfg_data;
        vspvc_pkg::REG_STEP_TIME:     st_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  vspvc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  vspvc_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_action, .in_box_width, .in_box_center,
    .in_quat_w, .in_quat_x, .in_quat_y, .in_quat_z,
    .target_width(tw_r), .target_center(tc_r),
    .dist_kp(dkp_r), .dist_ki(dki_r), .turn_kp(tkp_r), .turn_ki(tki_r),
    .step_time(st_r),
    .out_vel_north, .out_vel_east, .out_yaw_rate
  );

endmodule
`default_nettype wire

FILE: sv/vspvc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vspvc_ctrl
// Sequencer: integrate, command, cordic, output (attitude items: cordic only).
// ----------------------------------------------------------------------------
module vspvc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire vspvc_pkg::vspvc_sts_t sts,
  output vspvc_pkg::vspvc_cmd_t     cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_INTEG = 10'b0000000100,
    S_MULA  = 10'b0000001000,
    S_MULB  = 10'b0000010000,
    S_CMD   = 10'b0000100000,
    S_ROTI  = 10'b0001000000,
    S_ITER  = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_HOLD  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_att) begin
          cmd.att_init = 1'b1;
          state_nxt    = S_ITER;
        end else begin
          state_nxt = S_INTEG;
        end
      end
      S_INTEG: begin
        cmd.integ = 1'b1;
        state_nxt = S_MULA;
      end
      S_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_CMD;
      end
      S_CMD: begin
        cmd.cmd   = 1'b1;
        state_nxt = S_ROTI;
      end
      S_ROTI: begin
        cmd.rot_init = 1'b1;
        state_nxt    = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (sts.iter_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.is_att) begin
          cmd.head_wr = 1'b1;
          state_nxt   = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/vspvc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vspvc_dp
// Datapath: PI integrators, command products, shared cordic, output rounding.
// ----------------------------------------------------------------------------
module vspvc_dp #(
  parameter int CORDIC_STEPS = vspvc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire vspvc_pkg::vspvc_cmd_t cmd,
  output vspvc_pkg::vspvc_sts_t      sts,
  input  wire logic                  in_action,
  input  wire logic [11:0]           in_box_width,
  input  wire logic [11:0]           in_box_center,
  input  wire logic signed [15:0]    in_quat_w,
  input  wire logic signed [15:0]    in_quat_x,
  input  wire logic signed [15:0]    in_quat_y,
  input  wire logic signed [15:0]    in_quat_z,
  input  wire logic [11:0]           target_width,
  input  wire logic [11:0]           target_center,
  input  wire logic [15:0]           dist_kp,
  input  wire logic [15:0]           dist_ki,
  input  wire logic [15:0]           turn_kp,
  input  wire logic [15:0]           turn_ki,
  input  wire logic [15:0]           step_time,
  output logic signed [15:0]         out_vel_north,
  output logic signed [15:0]         out_vel_east,
  output logic signed [14:0]         out_yaw_rate
);

  localparam int CW    = vspvc_pkg::CW;
  localparam int NSTEP = (CORDIC_STEPS < vspvc_pkg::ANGLE_ENTRIES) ?
                         CORDIC_STEPS : vspvc_pkg::ANGLE_ENTRIES;
  localparam logic [4:0] LAST = 5'(NSTEP - 1);

  logic               att_r;
  logic signed [12:0] derr_r, terr_r;
  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [31:0] dint_r, tint_r;
  logic [15:0]        heading_r;
  logic signed [49:0] pd_r, id_r, pt_r, it_r;
  logic signed [17:0] speed_r;
  logic signed [14:0] rate_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic [31:0]        cz_r;
  logic [4:0]         i_r;
  logic               vec_r;
  logic signed [15:0] north_r, east_r;
  logic signed [14:0] yaw_r;

  assign sts.is_att    = att_r;
  assign sts.iter_last = (i_r == LAST);

  // integrator update with saturation and sign-opposition clear
  function automatic logic signed [31:0] integ_upd(input logic signed [31:0] a,
                                                   input logic signed [12:0] e,
                                                   input logic [15:0] st);
    logic signed [29:0] inc;
    logic signed [33:0] s;
    logic signed [31:0] r;
    begin
      inc = 30'(e * $signed({1'b0, st}));
      s   = 34'(a) + 34'(inc);
      if (s > 34'sh7FFFFFFF) r = 32'sh7FFFFFFF;
      else if (s < -34'sh80000000) r = 32'sh80000000;
      else r = s[31:0];
      if ((r < 0 && inc > 0) || (r > 0 && inc < 0)) r = '0;
      return r;
    end
  endfunction

  // clamp then round Q.32 sum to Q2.14
  function automatic logic signed [17:0] cmd_round(input logic signed [50:0] s,
                                                   input logic signed [50:0] lim);
    logic signed [50:0] c;
    begin
      if (s > lim) c = lim;
      else if (s < -lim) c = -lim;
      else c = s;
      c = c + 51'sd131072;
      return 18'(c >>> 18);
    end
  endfunction

  function automatic logic signed [15:0] vel_round(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    begin
      t = (v + CW'(64'sd536870912)) >>> 30;
      if (t > CW'(16384)) t = CW'(16384);
      else if (t < -CW'(16384)) t = -CW'(16384);
      return t[15:0];
    end
  endfunction

  logic signed [33:0] num_c, den_c;
  logic signed [CW-1:0] dx_c, dy_c;
  logic [31:0] ang_c, hz_c;
  logic signed [CW-1:0] rx0_c;
  logic dir_c;

  always_comb begin
    num_c = 34'(2 * (34'(qw_r * qz_r) + 34'(qx_r * qy_r)));
    den_c = 34'(qw_r * qw_r) + 34'(qx_r * qx_r) - 34'(qy_r * qy_r) - 34'(qz_r * qz_r);
    dx_c  = cy_r >>> i_r;
    dy_c  = cx_r >>> i_r;
    ang_c = vspvc_pkg::angle_at(i_r);
    hz_c  = {heading_r, 16'h0};
    rx0_c = CW'(speed_r * $signed({1'b0, vspvc_pkg::CORDIC_K}));
    // rotate direction: vectoring drives y to 0, rotation drives z to 0
    dir_c = vec_r ? !cy_r[CW-1] : !cz_r[31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dint_r    <= '0;
      tint_r    <= '0;
      heading_r <= '0;
    end else begin
      if (cmd.integ) begin
        dint_r <= integ_upd(dint_r, derr_r, step_time);
        tint_r <= integ_upd(tint_r, terr_r, step_time);
      end
      if (cmd.head_wr) heading_r <= 16'((cz_r + 32'h8000) >> 16);
    end
  end

  // item capture, products, command rounding, cordic, output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      att_r  <= in_action;
      derr_r <= $signed({1'b0, target_width}) - $signed({1'b0, in_box_width});
      terr_r <= $signed({1'b0, in_box_center}) - $signed({1'b0, target_center});
      qw_r <= in_quat_w; qx_r <= in_quat_x; qy_r <= in_quat_y; qz_r <= in_quat_z;
    end
    if (cmd.mul_a) begin
      pd_r <= 50'(derr_r * $signed({1'b0, dist_kp}));
      id_r <= 50'(dint_r * $signed({1'b0, dist_ki}));
    end
    if (cmd.mul_b) begin
      pt_r <= 50'(terr_r * $signed({1'b0, turn_kp}));
      it_r <= 50'(tint_r * $signed({1'b0, turn_ki}));
    end
    if (cmd.cmd) begin
      speed_r <= cmd_round(51'(pd_r) * 51'sd65536 + 51'(id_r), 51'sh1_0000_0000);
      rate_r  <= 15'(cmd_round(51'(pt_r) * 51'sd65536 + 51'(it_r), 51'sh0_C000_0000));
    end
    if (cmd.att_init) begin
      vec_r <= 1'b1;
      i_r   <= '0;
      if (den_c == 0 && num_c == 0) begin
        cx_r <= '0; cy_r <= '0; cz_r <= '0;
      end else if (den_c < 0) begin
        cx_r <= -CW'(den_c); cy_r <= -CW'(num_c); cz_r <= vspvc_pkg::TURN_HALF;
      end else begin
        cx_r <= CW'(den_c); cy_r <= CW'(num_c); cz_r <= '0;
      end
    end
    if (cmd.rot_init) begin
      vec_r <= 1'b0;
      i_r   <= '0;
      cy_r  <= '0;
      if (hz_c[31:30] == 2'd1 || hz_c[31:30] == 2'd2) begin
        cx_r <= -rx0_c; cz_r <= hz_c - vspvc_pkg::TURN_HALF;
      end else begin
        cx_r <= rx0_c;  cz_r <= hz_c;
      end
    end
    if (cmd.iter) begin
      // zero quaternion stays at zero: x, y and the angle all hold
      if (vec_r && cx_r == 0 && cy_r == 0) begin
        cz_r <= cz_r;
      end else if (vec_r ? dir_c : dir_c) begin
        if (vec_r) begin
          cx_r <= cx_r + dx_c; cy_r <= cy_r - dy_c; cz_r <= cz_r + ang_c;
        end else begin
          cx_r <= cx_r - dx_c; cy_r <= cy_r + dy_c; cz_r <= cz_r - ang_c;
        end
      end else begin
        if (vec_r) begin
          cx_r <= cx_r - dx_c; cy_r <= cy_r + dy_c; cz_r <= cz_r - ang_c;
        end else begin
          cx_r <= cx_r + dx_c; cy_r <= cy_r - dy_c; cz_r <= cz_r + ang_c;
        end
      end
      i_r <= i_r + 5'd1;
    end
    if (cmd.fin) begin
      north_r <= vel_round(cx_r);
      east_r  <= vel_round(cy_r);
      yaw_r   <= rate_r;
    end
  end

  assign out_vel_north = north_r;
  assign out_vel_east  = east_r;
  assign out_yaw_rate  = yaw_r;

endmodule
`default_nettype wire
